@@ hdl/gn3d_pkg.sv @@
// Shared constants and arithmetic helpers for the 3D gradient noise unit.
package gn3d_pkg;

	localparam int DEF_TABLE_SIZE = 256;
	localparam int DEF_FRAC_BITS  = 16;

	localparam int COORD_W = 24;
	localparam int ENTRY_W = 8;
	localparam int OUT_W   = 18;
	localparam int OUT_FRAC = 16;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 24;

	localparam logic signed [63:0] OUT_MAX = 64'sd131071;
	localparam logic signed [63:0] OUT_MIN = -64'sd131072;

	// Gradient codes that reuse x as the second term, and thresholds that pick y for u and v.
	localparam logic [3:0] GRAD_XV_A = 4'd12;
	localparam logic [3:0] GRAD_XV_B = 4'd14;
	localparam logic [3:0] GRAD_U_Y  = 4'd8;
	localparam logic [3:0] GRAD_V_Y  = 4'd4;

	// Round a signed value to sh fewer fraction bits, ties away from zero.
	function automatic logic signed [63:0] rnd(input logic signed [63:0] p, input int sh);
		logic [63:0] m;
		m = p[63] ? 64'(-p) : 64'(p);
		m = (m + (64'(1) << (sh - 1))) >> sh;
		return p[63] ? -$signed(m) : $signed(m);
	endfunction

	// Sixteen-way gradient dot product for one cube corner.
	function automatic logic signed [63:0] grad(input logic [3:0] h,
			input logic signed [63:0] x, input logic signed [63:0] y,
			input logic signed [63:0] z);
		logic signed [63:0] u;
		logic signed [63:0] v;
		u = (h < GRAD_U_Y) ? x : y;
		if (h < GRAD_V_Y) begin
			v = y;
		end else if (h == GRAD_XV_A || h == GRAD_XV_B) begin
			v = x;
		end else begin
			v = z;
		end
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

endpackage

@@ hdl/gradient_noise_3d_unit.sv @@
// Pipelined 3D improved gradient noise evaluator with a loadable permutation table.
//
//  Channel   Signals                     Carries
//  -------   -------------------------   ---------------------------------------------
//  s_axis    tvalid tready tdata tuser   evaluate request (tuser 0) or table write (1)
//  m_axis    tvalid tready tdata         one noise value per evaluate request
//
// The datapath is a seventeen-stage pipeline; a new evaluate request can enter in every
// cycle when the output is not held, and its result is presented from the last stage.
// The three table look-up levels read seven replicated copies of the permutation table,
// so the sustained rate of one request per cycle is set by those copies' read ports.
// A table write is held off while an evaluate request still sits in the first two
// stages, whose table reads are yet to come.
// Reset clears the valid bits of all stages and of the table; an entry never written
// reads as its own index. Stalls from the output collapse bubbles stage by stage.
module gradient_noise_3d_unit #(
	parameter int TABLE_SIZE = gn3d_pkg::DEF_TABLE_SIZE,
	parameter int FRAC_BITS  = gn3d_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// table_index[7:0], table_value[15:8], coord_x[39:16], coord_y[63:40], coord_z[87:64]
	input  logic [gn3d_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// action[0]
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// noise_value[17:0], zero fill [23:18]
	output logic [gn3d_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int F  = FRAC_BITS;
	// Working width: holds the fade inner term, which reaches -15.
	localparam int VW = F + 5;
	localparam int PW = 2 * VW;
	localparam int NS = 17;
	localparam int NCOPY = 7;
	localparam int SHR = (F > gn3d_pkg::OUT_FRAC) ? F - gn3d_pkg::OUT_FRAC : 1;
	localparam int SHL = (F < gn3d_pkg::OUT_FRAC) ? gn3d_pkg::OUT_FRAC - F : 0;
	localparam logic signed [VW-1:0] ONE_Q     = VW'(1) << F;
	localparam logic signed [VW-1:0] FIFTEEN_Q = VW'(15) << F;
	localparam logic signed [VW-1:0] TEN_Q     = VW'(10) << F;

	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [PW-1:0] prod_t;

	// Handshake and stage flow control.
	logic              eval_acc;
	logic              wr_acc;
	logic [NS:1]       vld_q;
	logic [NS+1:1]     adv;

	always_comb begin
		adv[NS+1] = m_axis_tready;
		for (int k = NS; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	// A table write must not overtake an evaluate request whose reads are still due.
	assign s_axis_tready = s_axis_tuser ? (!vld_q[1] && !vld_q[2]) : adv[1];
	assign eval_acc = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
	assign wr_acc   = s_axis_tvalid && s_axis_tready && s_axis_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = NS; k >= 2; k--) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (adv[1]) begin
				vld_q[1] <= eval_acc;
			end
		end
	end

	// Request fields.
	logic [IW-1:0]      wr_addr;
	logic [7:0]         wr_data;
	logic [23:0]        coord [3];
	logic [IW-1:0]      cell_in [3];

	assign wr_addr  = IW'(s_axis_tdata[7:0]);
	assign wr_data  = s_axis_tdata[15:8];
	assign coord[0] = s_axis_tdata[39:16];
	assign coord[1] = s_axis_tdata[63:40];
	assign coord[2] = s_axis_tdata[87:64];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cell_in[k] = IW'(coord[k] >> F);
		end
	end

	// Permutation table: valid bits in flip-flops, data in seven replicated copies.
	logic [TABLE_SIZE-1:0] tbl_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (wr_acc) begin
			tbl_vld_q[wr_addr] <= 1'b1;
		end
	end

	logic [IW-1:0] raddr  [NCOPY][2];
	logic          rd_en  [NCOPY];
	logic [7:0]    pt_val [NCOPY][2];

	logic [IW-1:0] iy_s1;
	logic [IW-1:0] iz_s1;
	logic [IW-1:0] iz_s2;
	logic [IW-1:0] hash_a;
	logic [IW-1:0] hash_b;
	logic [IW-1:0] hash_c [4];

	always_comb begin
		hash_a = IW'(pt_val[0][0]) + iy_s1;
		hash_b = IW'(pt_val[0][1]) + iy_s1;
		for (int c = 0; c < 4; c++) begin
			hash_c[c] = IW'(pt_val[1 + c / 2][c % 2]) + iz_s2;
		end
		// First level: the x cell and its neighbour.
		raddr[0][0] = cell_in[0];
		raddr[0][1] = cell_in[0] + IW'(1);
		rd_en[0]    = adv[1];
		raddr[1][0] = hash_a;
		raddr[1][1] = hash_a + IW'(1);
		rd_en[1]    = adv[2];
		raddr[2][0] = hash_b;
		raddr[2][1] = hash_b + IW'(1);
		rd_en[2]    = adv[2];
		// Last level: copies hold aa, ab, ba, bb with their z neighbours.
		for (int c = 0; c < 4; c++) begin
			raddr[3+c][0] = hash_c[c];
			raddr[3+c][1] = hash_c[c] + IW'(1);
			rd_en[3+c]    = adv[3];
		end
	end

	for (genvar g = 0; g < NCOPY; g++) begin : g_copy
		logic [7:0]    mem [TABLE_SIZE];
		logic [7:0]    rdat_q [2];
		logic          rvld_q [2];
		logic [IW-1:0] radr_q [2];

		always_ff @(posedge clk) begin
			if (wr_acc) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en[g]) begin
				for (int p = 0; p < 2; p++) begin
					rdat_q[p] <= mem[raddr[g][p]];
					rvld_q[p] <= tbl_vld_q[raddr[g][p]];
					radr_q[p] <= raddr[g][p];
				end
			end
		end

		for (genvar p = 0; p < 2; p++) begin : g_port
			assign pt_val[g][p] = rvld_q[p] ? rdat_q[p] : 8'(radr_q[p]);
		end
	end

	// Arithmetic pipeline.
	logic [F-1:0] f_s1 [3];
	logic [F-1:0] f_s2 [3];
	logic [F-1:0] f_s3 [3];
	prod_t        ptt_s2 [3];
	prod_t        pin_s2 [3];
	val_t         tt_s3  [3];
	val_t         inr_s3 [3];
	val_t         inr_s4 [3];
	val_t         inr_s5 [3];
	prod_t        p3_s4  [3];
	val_t         t3_s5  [3];
	prod_t        pf_s6  [3];
	val_t         g_s4 [8];
	val_t         g_s5 [8];
	val_t         g_s6 [8];
	val_t         g_s7 [8];
	val_t         fd_s7  [3];
	val_t         fd_s8  [3];
	val_t         fd_s9  [3];
	val_t         fd_s10 [3];
	val_t         fd_s11 [3];
	val_t         fd_s12 [3];
	val_t         fd_s13 [3];
	val_t         fd_s14 [3];
	val_t         d_s8  [4];
	val_t         a_s8  [4];
	prod_t        p_s9  [4];
	val_t         a_s9  [4];
	val_t         l_s10 [4];
	val_t         d_s11 [2];
	val_t         a_s11 [2];
	prod_t        p_s12 [2];
	val_t         a_s12 [2];
	val_t         l_s13 [2];
	val_t         d_s14;
	val_t         a_s14;
	prod_t        p_s15;
	val_t         a_s15;
	val_t         r_s16;
	logic signed [gn3d_pkg::OUT_W-1:0] out_s17;

	val_t               fs1   [3];
	val_t               fs3   [3];
	val_t               inner [3];
	val_t               near  [3];
	val_t               far   [3];
	logic [3:0]         hcorn [8];
	logic signed [63:0] conv;
	logic signed [63:0] r_wide;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fs1[k]   = val_t'({1'b0, f_s1[k]});
			fs3[k]   = val_t'({1'b0, f_s3[k]});
			inner[k] = (fs1[k] <<< 2) + (fs1[k] <<< 1) - FIFTEEN_Q;
			near[k]  = fs3[k];
			far[k]   = fs3[k] - ONE_Q;
		end
		for (int c = 0; c < 8; c++) begin
			hcorn[c] = pt_val[3 + 2 * (c % 2) + (c / 2) % 2][c / 4][3:0];
		end
		r_wide = 64'(r_s16);
		if (F > gn3d_pkg::OUT_FRAC) begin
			conv = gn3d_pkg::rnd(r_wide, SHR);
		end else begin
			conv = r_wide <<< SHL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int k = 0; k < 3; k++) begin
				f_s1[k] <= coord[k][F-1:0];
			end
			iy_s1 <= cell_in[1];
			iz_s1 <= cell_in[2];
		end
		if (adv[2]) begin
			for (int k = 0; k < 3; k++) begin
				f_s2[k]   <= f_s1[k];
				ptt_s2[k] <= fs1[k] * fs1[k];
				pin_s2[k] <= fs1[k] * inner[k];
			end
			iz_s2 <= iz_s1;
		end
		if (adv[3]) begin
			for (int k = 0; k < 3; k++) begin
				f_s3[k]   <= f_s2[k];
				tt_s3[k]  <= VW'(gn3d_pkg::rnd(64'(ptt_s2[k]), F));
				inr_s3[k] <= VW'(gn3d_pkg::rnd(64'(pin_s2[k]), F)) + TEN_Q;
			end
		end
		if (adv[4]) begin
			for (int k = 0; k < 3; k++) begin
				p3_s4[k]  <= tt_s3[k] * fs3[k];
				inr_s4[k] <= inr_s3[k];
			end
			// Corner bits: x in bit 0, y in bit 1, z in bit 2.
			for (int c = 0; c < 8; c++) begin
				g_s4[c] <= VW'(gn3d_pkg::grad(hcorn[c],
					64'((c % 2 == 1) ? far[0] : near[0]),
					64'(((c / 2) % 2 == 1) ? far[1] : near[1]),
					64'((c / 4 == 1) ? far[2] : near[2])));
			end
		end
		if (adv[5]) begin
			for (int k = 0; k < 3; k++) begin
				t3_s5[k]  <= VW'(gn3d_pkg::rnd(64'(p3_s4[k]), F));
				inr_s5[k] <= inr_s4[k];
			end
			g_s5 <= g_s4;
		end
		if (adv[6]) begin
			for (int k = 0; k < 3; k++) begin
				pf_s6[k] <= t3_s5[k] * inr_s5[k];
			end
			g_s6 <= g_s5;
		end
		if (adv[7]) begin
			for (int k = 0; k < 3; k++) begin
				fd_s7[k] <= VW'(gn3d_pkg::rnd(64'(pf_s6[k]), F));
			end
			g_s7 <= g_s6;
		end
		// Blend along x.
		if (adv[8]) begin
			for (int j = 0; j < 4; j++) begin
				d_s8[j] <= g_s7[2*j+1] - g_s7[2*j];
				a_s8[j] <= g_s7[2*j];
			end
			fd_s8 <= fd_s7;
		end
		if (adv[9]) begin
			for (int j = 0; j < 4; j++) begin
				p_s9[j] <= fd_s8[0] * d_s8[j];
			end
			a_s9  <= a_s8;
			fd_s9 <= fd_s8;
		end
		if (adv[10]) begin
			for (int j = 0; j < 4; j++) begin
				l_s10[j] <= a_s9[j] + VW'(gn3d_pkg::rnd(64'(p_s9[j]), F));
			end
			fd_s10 <= fd_s9;
		end
		// Blend along y.
		if (adv[11]) begin
			for (int j = 0; j < 2; j++) begin
				d_s11[j] <= l_s10[2*j+1] - l_s10[2*j];
				a_s11[j] <= l_s10[2*j];
			end
			fd_s11 <= fd_s10;
		end
		if (adv[12]) begin
			for (int j = 0; j < 2; j++) begin
				p_s12[j] <= fd_s11[1] * d_s11[j];
			end
			a_s12  <= a_s11;
			fd_s12 <= fd_s11;
		end
		if (adv[13]) begin
			for (int j = 0; j < 2; j++) begin
				l_s13[j] <= a_s12[j] + VW'(gn3d_pkg::rnd(64'(p_s12[j]), F));
			end
			fd_s13 <= fd_s12;
		end
		// Blend along z.
		if (adv[14]) begin
			d_s14  <= l_s13[1] - l_s13[0];
			a_s14  <= l_s13[0];
			fd_s14 <= fd_s13;
		end
		if (adv[15]) begin
			p_s15 <= fd_s14[2] * d_s14;
			a_s15 <= a_s14;
		end
		if (adv[16]) begin
			r_s16 <= a_s15 + VW'(gn3d_pkg::rnd(64'(p_s15), F));
		end
		// Scale to sixteen fraction bits and saturate.
		if (adv[17]) begin
			if (conv > gn3d_pkg::OUT_MAX) begin
				out_s17 <= gn3d_pkg::OUT_W'(gn3d_pkg::OUT_MAX);
			end else if (conv < gn3d_pkg::OUT_MIN) begin
				out_s17 <= gn3d_pkg::OUT_W'(gn3d_pkg::OUT_MIN);
			end else begin
				out_s17 <= gn3d_pkg::OUT_W'(conv);
			end
		end
	end

	assign m_axis_tvalid = vld_q[NS];
	assign m_axis_tdata  = {(gn3d_pkg::OUT_DATA_W - gn3d_pkg::OUT_W)'(0), out_s17};

endmodule

@@ dv/gradient_noise_3d_checker.sv @@
// Checker for the gradient noise unit: predicts each noise value and compares results.
module gradient_noise_3d_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [gn3d_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [gn3d_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output int                              fail_count,
	output int                              pending_count,
	output int                              result_count
);

	localparam int FB = gn3d_pkg::DEF_FRAC_BITS;
	localparam longint ONE = longint'(1) << FB;

	logic [7:0] perm_copy [256];
	logic [gn3d_pkg::OUT_W-1:0] noise_expected [$];

	// Product of two fixed-point values, rounded half away from zero.
	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		longint m;
		p = a * b;
		m = p < 0 ? -p : p;
		m = (m + (ONE >>> 1)) >>> FB;
		return p < 0 ? -m : m;
	endfunction

	function automatic longint fade_curve(input longint t);
		return fx_mul(fx_mul(fx_mul(t, t), t), fx_mul(t, 6 * t - 15 * ONE) + 10 * ONE);
	endfunction

	function automatic longint blend(input longint t, input longint a, input longint b);
		return a + fx_mul(t, b - a);
	endfunction

	function automatic longint corner_dot(input logic [7:0] hv, input longint x,
			input longint y, input longint z);
		logic [3:0] h;
		longint u;
		longint v;
		h = hv[3:0];
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic logic [7:0] hash_at(input int i);
		return perm_copy[i & 255];
	endfunction

	function automatic logic [gn3d_pkg::OUT_W-1:0] noise_at(input logic [23:0] cx,
			input logic [23:0] cy, input logic [23:0] cz);
		int ix, iy, iz, a, aa, ab, b, ba, bb;
		longint fx, fy, fz, u, v, w, x1, y1, z1, r;
		ix = cx[23:16]; iy = cy[23:16]; iz = cz[23:16];
		fx = cx[15:0]; fy = cy[15:0]; fz = cz[15:0];
		u = fade_curve(fx); v = fade_curve(fy); w = fade_curve(fz);
		a = hash_at(ix) + iy; aa = hash_at(a) + iz; ab = hash_at(a + 1) + iz;
		b = hash_at(ix + 1) + iy; ba = hash_at(b) + iz; bb = hash_at(b + 1) + iz;
		x1 = fx - ONE; y1 = fy - ONE; z1 = fz - ONE;
		r = blend(w,
			blend(v,
				blend(u, corner_dot(hash_at(aa), fx, fy, fz), corner_dot(hash_at(ba), x1, fy, fz)),
				blend(u, corner_dot(hash_at(ab), fx, y1, fz), corner_dot(hash_at(bb), x1, y1, fz))),
			blend(v,
				blend(u, corner_dot(hash_at(aa + 1), fx, fy, z1),
					corner_dot(hash_at(ba + 1), x1, fy, z1)),
				blend(u, corner_dot(hash_at(ab + 1), fx, y1, z1),
					corner_dot(hash_at(bb + 1), x1, y1, z1))));
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return r[gn3d_pkg::OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [gn3d_pkg::OUT_W-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) perm_copy[i] = i[7:0];
			noise_expected.delete();
			fail_count <= 0;
			result_count <= 0;
			pending_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_count <= result_count + 1;
				if (noise_expected.size() == 0) begin
					$display("%0t: unexpected noise result %h", $time, m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = noise_expected.pop_front();
					if (m_axis_tdata != {6'b0, want}) begin
						$display("%0t: noise mismatch, expected %h actual %h", $time,
							{6'b0, want}, m_axis_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser)
					perm_copy[s_axis_tdata[7:0]] = s_axis_tdata[15:8];
				else
					noise_expected.push_back(noise_at(s_axis_tdata[39:16],
						s_axis_tdata[63:40], s_axis_tdata[87:64]));
			end
			pending_count <= noise_expected.size();
		end
	end

endmodule

@@ dv/gradient_noise_3d_unit_tb.sv @@
// Testbench top for the gradient noise unit: stimulus, reset, clock and verdict.
module gradient_noise_3d_unit_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [gn3d_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [gn3d_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	int fail_count, pending_count, result_count;
	int cycle_count = 0;
	int write_count = 0;
	bit stall_free = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	gradient_noise_3d_unit dut (.*);

	gradient_noise_3d_checker chk (.*);

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_request(input bit is_write, input logic [7:0] idx,
			input logic [7:0] val, input logic [23:0] cx, input logic [23:0] cy,
			input logic [23:0] cz, input bit pace);
		int g;
		g = pace ? gap_length() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tuser <= is_write;
		s_axis_tdata <= {cz, cy, cx, val, idx};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (is_write) write_count++;
	endtask

	// Withdraw the input and wait until every expected result has come back.
	task automatic drain_pipe();
		s_axis_tvalid <= 1'b0;
		wait (pending_count == 0);
		@(negedge clk);
	endtask

	task automatic evaluate_at(input logic [23:0] cx, input logic [23:0] cy,
			input logic [23:0] cz, input bit pace);
		send_request(1'b0, 8'($urandom), 8'($urandom), cx, cy, cz, pace);
	endtask

	// Coordinates that cluster on lattice faces and fraction extremes as well as random ones.
	function automatic logic [23:0] random_coord();
		logic [23:0] c;
		c = 24'($urandom);
		case ($urandom_range(0, 5))
			0: c[15:0] = 16'h0000;
			1: c[15:0] = 16'hFFFF;
			2: c[23:16] = 8'hFF;
			default: ;
		endcase
		return c;
	endfunction

	// The receiver stalls at random except during stall-free stretches.
	always @(negedge clk) begin
		if (stall_free)
			m_axis_tready <= 1'b1;
		else if ($urandom_range(0, 99) < 3)
			m_axis_tready <= 1'b0;
		else if (!m_axis_tready)
			m_axis_tready <= ($urandom_range(0, 3) == 0);
		else
			m_axis_tready <= ($urandom_range(0, 99) >= 25);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int n;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: identity table, coordinate extremes and lattice corners.
		evaluate_at(24'h000000, 24'h000000, 24'h000000, 1'b0);
		evaluate_at(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
		evaluate_at(24'h008000, 24'h008000, 24'h008000, 1'b0);
		evaluate_at(24'hFF0000, 24'h00FFFF, 24'hAA5555, 1'b0);
		evaluate_at(24'h55AAAA, 24'hFF8000, 24'h000001, 1'b0);
		evaluate_at(24'h01C000, 24'h024000, 24'hFEFFFF, 1'b0);
		// Table writes at both ends, then look-ups that wrap past the last entry.
		send_request(1'b1, 8'h00, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
		send_request(1'b1, 8'hFF, 8'h00, 24'h0, 24'h0, 24'h0, 1'b0);
		send_request(1'b1, 8'h80, 8'h7F, 24'h0, 24'h0, 24'h0, 1'b0);
		evaluate_at(24'hFF8000, 24'hFF8000, 24'hFF8000, 1'b0);
		evaluate_at(24'h00FFFF, 24'hFFFFFF, 24'h7F4000, 1'b0);
		// Corners all pulling one way, to push the sum towards saturation.
		for (int i = 0; i < 6; i++)
			evaluate_at({8'(i * 37), 16'h8000}, {8'(i * 11), 16'h7FFF},
				{8'(i * 5), 16'h8001}, 1'b0);

		// Pause until the pipe has drained before the random part.
		drain_pipe();

		// Random: evaluations mixed with table rewrites.
		n = 0;
		while (n < 1400) begin
			if (n % 200 == 100) stall_free = 1'b1;
			if (n % 200 == 150) stall_free = 1'b0;
			if ($urandom_range(0, 99) < 12)
				send_request(1'b1, 8'($urandom), 8'($urandom), 24'($urandom),
					24'($urandom), 24'($urandom), 1'b1);
			else
				evaluate_at(random_coord(), random_coord(), random_coord(),
					n % 200 >= 100 && n % 200 < 150 ? 1'b0 : 1'b1);
			n++;
			if (n == 700) drain_pipe();
		end

		stall_free = 1'b0;
		drain_pipe();
		repeat (40) @(posedge clk);
		$display("Covered %0d noise results and %0d table writes, with stalls and gaps.",
			result_count, write_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/gn3d_pkg.sv
hdl/gradient_noise_3d_unit.sv
dv/gradient_noise_3d_checker.sv
dv/gradient_noise_3d_unit_tb.sv
